>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Define ASSERT_OFF to compile all assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clock, reset, cond, msg)
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)

`endif

`endif

>>> rtl/ibfr_pkg.sv
package ibfr_pkg;

  typedef logic [4:0]  pos_t;
  typedef logic [15:0] cksum_t;
  typedef logic [11:0] chan_t;
  typedef logic [3:0]  fsafe_t;
  typedef logic [7:0]  byte_t;

  localparam byte_t  HDR_FIRST      = 8'h20;
  localparam byte_t  HDR_SECOND     = 8'h40;
  localparam cksum_t CKSUM_INIT     = 16'hFFFF;
  localparam chan_t  THRESH_RESET   = 12'd1010;
  localparam int     NUM_CHAN       = 6;
  localparam int     NUM_CHAN_BYTES = 12;

  // Frame byte positions.
  localparam pos_t POS_HDR_FIRST  = 5'd0;
  localparam pos_t POS_HDR_SECOND = 5'd1;
  localparam pos_t POS_CHAN_FIRST = 5'd2;
  localparam pos_t POS_CHAN_LAST  = 5'd13;
  localparam pos_t POS_CKSUM_LO   = 5'd30;
  localparam pos_t POS_LAST       = 5'd31;

  // Register index on the configuration port.
  localparam logic REG_THRESH = 1'b0;

  typedef struct packed {
    logic                      frame_ok;
    chan_t [NUM_CHAN-1:0]      chans;
    fsafe_t                    failsafe;
    logic                      throttle_low;
  } result_t;

  typedef struct packed {
    logic at_last;     // next byte closes the frame
    logic frame_done;  // the closing byte is taken this cycle
  } parse_ev_t;

endpackage

>>> rtl/ibfr_parser.sv
module ibfr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  ibfr_pkg::byte_t    rx_byte,
  input  ibfr_pkg::chan_t    threshold,
  output ibfr_pkg::parse_ev_t ev,
  output ibfr_pkg::result_t  result
);
  import ibfr_pkg::*;

  pos_t   pos, pos_next;
  cksum_t cksum, cksum_next;
  byte_t  chan_bytes [NUM_CHAN_BYTES];
  byte_t  cksum_lo;
  chan_t  held [NUM_CHAN];
  fsafe_t held_fsafe;

  pos_t            chan_off;
  logic [3:0]      chan_idx;
  logic            chan_wr;
  logic            ok;
  chan_t [NUM_CHAN-1:0] fresh;

  assign chan_off = pos - POS_CHAN_FIRST;
  assign chan_idx = chan_off[3:0];
  assign chan_wr  = take && (pos >= POS_CHAN_FIRST) && (pos <= POS_CHAN_LAST);

  always_comb begin
    pos_next   = pos;
    cksum_next = cksum;
    if (take) begin
      if (pos == POS_HDR_FIRST) begin
        if (rx_byte == HDR_FIRST) begin
          pos_next   = POS_HDR_SECOND;
          cksum_next = CKSUM_INIT - {8'h00, rx_byte};
        end
      end else if (pos == POS_HDR_SECOND) begin
        // A bad second byte restarts the hunt without being rechecked.
        if (rx_byte == HDR_SECOND) begin
          pos_next   = POS_CHAN_FIRST;
          cksum_next = cksum - {8'h00, rx_byte};
        end else begin
          pos_next   = POS_HDR_FIRST;
          cksum_next = CKSUM_INIT;
        end
      end else if (pos < POS_CKSUM_LO) begin
        pos_next   = pos + 5'd1;
        cksum_next = cksum - {8'h00, rx_byte};
      end else if (pos == POS_CKSUM_LO) begin
        pos_next = POS_LAST;
      end else begin
        pos_next   = POS_HDR_FIRST;
        cksum_next = CKSUM_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_HDR_FIRST;
      cksum <= CKSUM_INIT;
    end else begin
      pos   <= pos_next;
      cksum <= cksum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (chan_wr) begin
      chan_bytes[chan_idx] <= rx_byte;
    end
    if (take && pos == POS_CKSUM_LO) begin
      cksum_lo <= rx_byte;
    end
  end

  assign ev.at_last    = (pos == POS_LAST);
  assign ev.frame_done = take && (pos == POS_LAST);

  assign ok = ({rx_byte, cksum_lo} == cksum);

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      fresh[i] = {chan_bytes[2*i+1][3:0], chan_bytes[2*i]};
    end
  end

  always_comb begin
    result.frame_ok     = ok;
    result.throttle_low = ok && (fresh[2] < threshold);
    for (int i = 0; i < NUM_CHAN; i++) begin
      result.chans[i] = ok ? fresh[i] : held[i];
    end
    result.failsafe = ok ? chan_bytes[NUM_CHAN_BYTES-1][7:4] : held_fsafe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        held[i] <= '0;
      end
      held_fsafe <= '0;
    end else if (ev.frame_done && ok) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        held[i] <= fresh[i];
      end
      held_fsafe <= chan_bytes[NUM_CHAN_BYTES-1][7:4];
    end
  end

endmodule

>>> rtl/ibfr_out_reg.sv
module ibfr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ibfr_pkg::result_t din,
  input  logic              res_stall,
  output logic              res_valid,
  output ibfr_pkg::result_t dout
);
  import ibfr_pkg::*;

  logic res_valid_next;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

>>> rtl/ibus_frame_receiver.sv
// Channel  Direction  Handshake            Payload
// rx       in         rx_valid / rx_stall  rx_byte
// res      out        res_valid/res_stall  frame_ok, chan_one..chan_six, failsafe_bits,
//                                          throttle_low
// cfg      in         APB write/read       throttle_low_threshold at address 0
//
// One byte is taken per cycle unless rx stalls; a frame of 32 bytes gives one result in the
// cycle after its last byte is taken, held in the result register.
// Reset is synchronous and returns the parser to header hunt with zero held values.
// rx stalls only when the last byte of a frame arrives while an earlier result
// still waits in a stalled result register; all other bytes are taken at once.
module ibus_frame_receiver (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_stall,
  input  logic [7:0]             rx_byte,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   frame_ok,
  output logic [11:0]            chan_one,
  output logic [11:0]            chan_two,
  output logic [11:0]            chan_three,
  output logic [11:0]            chan_four,
  output logic [11:0]            chan_five,
  output logic [11:0]            chan_six,
  output logic [3:0]             failsafe_bits,
  output logic                   throttle_low,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import ibfr_pkg::*;

  chan_t     threshold;
  logic      take;
  logic      cfg_wr;
  parse_ev_t ev;
  result_t   result;
  result_t   res_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESH);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wr) begin
      threshold <= pwdata[11:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESH) ? {20'd0, threshold} : 32'd0;

  assign rx_stall = res_valid && res_stall && ev.at_last;
  assign take     = rx_valid && !rx_stall;

  ibfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .threshold (threshold),
    .ev        (ev),
    .result    (result)
  );

  ibfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (ev.frame_done),
    .din       (result),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .dout      (res_q)
  );

  assign frame_ok      = res_q.frame_ok;
  assign chan_one      = res_q.chans[0];
  assign chan_two      = res_q.chans[1];
  assign chan_three    = res_q.chans[2];
  assign chan_four     = res_q.chans[3];
  assign chan_five     = res_q.chans[4];
  assign chan_six      = res_q.chans[5];
  assign failsafe_bits = res_q.failsafe;
  assign throttle_low  = res_q.throttle_low;

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_stall_only_full, clk, rst, rx_stall, res_valid && res_stall && ev.at_last, "rx stalled without a blocked result")
  `ASSERT_IMPLIES(a_res_from_last, clk, rst, $rose(res_valid), $past(ev.frame_done), "result appeared without a closing byte")
  `ASSERT_IMPLIES(a_low_needs_ok, clk, rst, res_valid && throttle_low, frame_ok, "throttle low flagged on a bad frame")
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(ev.frame_done && res_valid && res_stall), "result register overwritten while stalled")

endmodule

>>> bench/ibus_frame_receiver_tb.sv
`timescale 1ns / 1ps

module ibus_frame_receiver_tb;
  import ibfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_BYTES = 96;
  localparam int PHASE_FRAMES = 3;
  localparam int MAX_PRINTS = 40;
  localparam logic [2:0] ADDR_THRESH = {REG_THRESH, 2'b00};
  // Next register slot; no register lives there.
  localparam logic [2:0] ADDR_SPARE = ADDR_THRESH + 3'd4;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]    npre;
    byte_t [0:2]   pre;
    logic          bad_sum;
    chan_t [0:5]   ch;
    fsafe_t        fs;
    logic          known;
    logic          exp_ok;
    logic          exp_low;
  } dir_row_t;

  // Rows with known set carry their expected flags (and channels, when good).
  // The reset threshold of 1010 is in effect during this part.
  localparam int NUM_ROWS = 11;
  localparam dir_row_t DIR_ROWS [0:NUM_ROWS-1] = '{
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0,
      '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 4'h0, 1'b1, 1'b1, 1'b1},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0,
      '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 4'hF, 1'b1, 1'b1, 1'b0},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b1,
      '{12'h123, 12'h456, 12'h789, 12'hABC, 12'hDEF, 12'h010}, 4'h5, 1'b1, 1'b0, 1'b0},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0,
      '{12'd100, 12'd200, 12'd1009, 12'd300, 12'd400, 12'd500}, 4'h0, 1'b1, 1'b1, 1'b1},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0,
      '{12'd100, 12'd200, 12'd1010, 12'd300, 12'd400, 12'd500}, 4'h8, 1'b1, 1'b1, 1'b0},
    '{2'd3, '{8'h40, 8'hFF, 8'h00}, 1'b0,
      '{12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6}, 4'h1, 1'b0, 1'b0, 1'b0},
    '{2'd3, '{8'h20, 8'h20, 8'h40}, 1'b0,
      '{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}, 4'hA, 1'b0, 1'b0, 1'b0},
    '{2'd2, '{8'h20, 8'hBF, 8'h00}, 1'b0,
      '{12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA}, 4'h5, 1'b0, 1'b0, 1'b0},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b1,
      '{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000}, 4'hC, 1'b0, 1'b0, 1'b0},
    '{2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0,
      '{12'h800, 12'h7FF, 12'h001, 12'hFFE, 12'h400, 12'h3FF}, 4'h7, 1'b0, 1'b0, 1'b0},
    '{2'd1, '{8'h40, 8'h00, 8'h00}, 1'b1,
      '{12'h321, 12'h654, 12'h987, 12'hCBA, 12'hFED, 12'h0F0}, 4'h3, 1'b0, 1'b0, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        frame_ok;
  logic [11:0] chan_one;
  logic [11:0] chan_two;
  logic [11:0] chan_three;
  logic [11:0] chan_four;
  logic [11:0] chan_five;
  logic [11:0] chan_six;
  logic [3:0]  failsafe_bits;
  logic        throttle_low;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ibus_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .frame_ok(frame_ok),
    .chan_one(chan_one),
    .chan_two(chan_two),
    .chan_three(chan_three),
    .chan_four(chan_four),
    .chan_five(chan_five),
    .chan_six(chan_six),
    .failsafe_bits(failsafe_bits),
    .throttle_low(throttle_low),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Decoder model state.
  pos_t    mdl_pos;
  cksum_t  mdl_sum;
  byte_t   mdl_chan_bytes [NUM_CHAN_BYTES];
  byte_t   mdl_sum_lo;
  chan_t   mdl_held [NUM_CHAN];
  fsafe_t  mdl_failsafe;
  chan_t   mdl_thresh;

  result_t pending_frames [$];
  dir_row_t typed_row;
  bit      typed_on;

  int      idle_pct;
  int      stall_pct;
  int      error_count;
  int      cycle_count = 0;
  int      bytes_sent;
  int      frames_predicted;
  int      frames_checked;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames outstanding",
               cycle_count, pending_frames.size());
      $display("FAIL ibus_frame_receiver");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Advances the decoder by one byte; returns 1 when the byte closes a frame.
  function automatic bit decode_byte(input byte_t b);
    result_t r;
    logic    ok;
    if (mdl_pos == POS_HDR_FIRST) begin
      if (b == HDR_FIRST) begin
        mdl_sum = CKSUM_INIT - b;
        mdl_pos = POS_HDR_SECOND;
      end
      return 1'b0;
    end
    if (mdl_pos == POS_HDR_SECOND) begin
      // A wrong second byte is not taken as a new first header byte.
      if (b == HDR_SECOND) begin
        mdl_sum = mdl_sum - b;
        mdl_pos = POS_CHAN_FIRST;
      end else begin
        mdl_sum = CKSUM_INIT;
        mdl_pos = POS_HDR_FIRST;
      end
      return 1'b0;
    end
    if (mdl_pos < POS_CKSUM_LO) begin
      if (mdl_pos <= POS_CHAN_LAST) mdl_chan_bytes[mdl_pos - POS_CHAN_FIRST] = b;
      mdl_sum = mdl_sum - b;
      mdl_pos = mdl_pos + 1'b1;
      return 1'b0;
    end
    if (mdl_pos == POS_CKSUM_LO) begin
      mdl_sum_lo = b;
      mdl_pos = POS_LAST;
      return 1'b0;
    end
    ok = ({b, mdl_sum_lo} == mdl_sum);
    if (ok) begin
      for (int i = 0; i < NUM_CHAN; i++)
        mdl_held[i] = {mdl_chan_bytes[2*i+1][3:0], mdl_chan_bytes[2*i]};
      mdl_failsafe = mdl_chan_bytes[NUM_CHAN_BYTES-1][7:4];
    end
    r.frame_ok = ok;
    for (int i = 0; i < NUM_CHAN; i++) r.chans[i] = mdl_held[i];
    r.failsafe = mdl_failsafe;
    r.throttle_low = ok && (mdl_held[2] < mdl_thresh);
    pending_frames.push_back(r);
    frames_predicted++;
    mdl_pos = POS_HDR_FIRST;
    mdl_sum = CKSUM_INIT;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result transfer with no frame pending", frame_ok, 0);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        check_field("frame_ok", frame_ok, want.frame_ok);
        check_field("chan_one", chan_one, want.chans[0]);
        check_field("chan_two", chan_two, want.chans[1]);
        check_field("chan_three", chan_three, want.chans[2]);
        check_field("chan_four", chan_four, want.chans[3]);
        check_field("chan_five", chan_five, want.chans[4]);
        check_field("chan_six", chan_six, want.chans[5]);
        check_field("failsafe_bits", failsafe_bits, want.failsafe);
        check_field("throttle_low", throttle_low, want.throttle_low);
      end
    end
  end

  task automatic send_byte(input byte_t b);
    result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
    if (decode_byte(b) && typed_on) begin
      r = pending_frames[pending_frames.size()-1];
      r.frame_ok = typed_row.exp_ok;
      r.throttle_low = typed_row.exp_low;
      if (typed_row.exp_ok) begin
        for (int i = 0; i < NUM_CHAN; i++) r.chans[i] = typed_row.ch[i];
        r.failsafe = typed_row.fs;
      end
      pending_frames[pending_frames.size()-1] = r;
    end
  endtask

  // Sends one 32-byte frame; unused upper nibbles of the channel bytes are random.
  task automatic send_frame(input chan_t [0:5] ch, input fsafe_t fs, input bit bad_sum);
    byte_t  fr [32];
    cksum_t s;
    fr[0] = HDR_FIRST;
    fr[1] = HDR_SECOND;
    for (int i = 0; i < NUM_CHAN; i++) begin
      fr[2+2*i] = ch[i][7:0];
      fr[3+2*i] = {4'($urandom), ch[i][11:8]};
    end
    fr[13][7:4] = fs;
    for (int i = 14; i < 30; i++) fr[i] = 8'($urandom);
    s = CKSUM_INIT;
    for (int i = 0; i < 30; i++) s = s - fr[i];
    if (bad_sum) s = s ^ 16'($urandom_range(1, 16'hFFFF));
    fr[30] = s[7:0];
    fr[31] = s[15:8];
    for (int i = 0; i < 32; i++) send_byte(fr[i]);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_THRESH) mdl_thresh = data[11:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_check_thresh();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_THRESH;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("threshold readback", prdata, {20'd0, mdl_thresh});
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    // Close any frame still open in the parser so that nothing is in flight.
    while (mdl_pos != POS_HDR_FIRST) send_byte(8'h00);
    @(negedge clk);
    rx_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // One random unit: mostly well-formed frames, some bad checksums, noise and broken starts.
  task automatic send_random_unit();
    chan_t [0:5] ch;
    fsafe_t      fs;
    int          sel;
    byte_t       b;
    for (int i = 0; i < NUM_CHAN; i++) ch[i] = pick_chan();
    // Put the throttle channel right at the threshold edge a third of the time.
    if ($urandom_range(0, 2) == 0) ch[2] = mdl_thresh + 12'($urandom_range(0, 4)) - 12'd2;
    fs = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      send_frame(ch, fs, 1'b0);
    end else if (sel < 82) begin
      send_frame(ch, fs, 1'b1);
    end else if (sel < 90) begin
      repeat ($urandom_range(1, 4)) begin
        b = ($urandom_range(0, 9) < 3) ? HDR_FIRST : 8'($urandom);
        send_byte(b);
      end
      send_frame(ch, fs, $urandom_range(0, 4) == 0);
    end else if (sel < 95) begin
      b = 8'($urandom);
      if (b == HDR_SECOND) b = HDR_FIRST;
      send_byte(HDR_FIRST);
      send_byte(b);
      send_frame(ch, fs, 1'b0);
    end else begin
      // A frame cut short; the next frame's bytes complete it.
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
      send_frame(ch, fs, 1'b0);
    end
  endtask

  function automatic void set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct = 57;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct = 57;
      end
      default: begin
        idle_pct = 7;
        stall_pct = 7;
      end
    endcase
  endfunction

  initial begin
    chan_t       phase_thresh [NUM_PHASES];
    int          first_bytes;
    int          first_frames;
    logic [31:0] wdata;

    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    bytes_sent = 0;
    frames_predicted = 0;
    frames_checked = 0;
    typed_on = 1'b0;
    mdl_pos = POS_HDR_FIRST;
    mdl_sum = CKSUM_INIT;
    mdl_sum_lo = 8'd0;
    for (int i = 0; i < NUM_CHAN_BYTES; i++) mdl_chan_bytes[i] = 8'd0;
    for (int i = 0; i < NUM_CHAN; i++) mdl_held[i] = 12'd0;
    mdl_failsafe = 4'd0;
    mdl_thresh = THRESH_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_check_thresh();

    set_idle(IDLE_NONE);
    for (int r = 0; r < NUM_ROWS; r++) begin
      typed_row = DIR_ROWS[r];
      typed_on = DIR_ROWS[r].known;
      for (int k = 0; k < DIR_ROWS[r].npre; k++) send_byte(DIR_ROWS[r].pre[k]);
      send_frame(DIR_ROWS[r].ch, DIR_ROWS[r].fs, DIR_ROWS[r].bad_sum);
    end
    typed_on = 1'b0;
    wait_idle();

    phase_thresh = '{12'd0, 12'hFFF, 12'($urandom), 12'd1, 12'hFFE,
                     12'($urandom), THRESH_RESET, 12'($urandom)};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Upper data bits are junk; only the low 12 bits land in the register.
      wdata = {20'($urandom), phase_thresh[ph]};
      cfg_write(ADDR_THRESH, wdata);
      cfg_check_thresh();
      if (ph == 3) begin
        cfg_write(ADDR_SPARE, $urandom);
        cfg_check_thresh();
      end
      set_idle(idle_mode_e'(ph % 4));
      first_bytes = bytes_sent;
      first_frames = frames_predicted;
      while (bytes_sent - first_bytes < PHASE_BYTES ||
             frames_predicted - first_frames < PHASE_FRAMES)
        send_random_unit();
      wait_idle();
    end

    $display("Sent %0d bytes, checked %0d frame results over %0d threshold/idle phases,",
             bytes_sent, frames_checked, NUM_PHASES);
    $display("including header faults, bad checksums, noise and cut-short frames.");
    if (error_count == 0) begin
      $display("PASS ibus_frame_receiver");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL ibus_frame_receiver");
    end
    $finish;
  end

endmodule
